FILE: design/grdp_pkg.sv
// ----------------------------------------------------------------------------
// grdp_pkg: shared types and constants of the grid A* planner
// Grid geometry, cost formats, cell store layout, controller states,
// datapath commands and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package grdp_pkg;

	localparam int GRID_W    = 64;
	localparam int GRID_H    = 64;
	localparam int FRAC_BITS = 8;

	localparam int XW    = $clog2(GRID_W);
	localparam int YW    = $clog2(GRID_H);
	localparam int AW    = XW + YW;
	localparam int NCELL = GRID_W * GRID_H;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W      = 2;
	localparam int FLAG_W    = 2;
	localparam int DIR_W     = 4;
	localparam int NB_W      = 3;
	localparam int COST_W    = 21;
	localparam int EST_W     = 22;

	localparam logic [COST_W-1:0] COST_MAX  = '1;
	localparam logic [EST_W-1:0]  EST_MAX   = '1;
	localparam logic [COST_W-1:0] STEP_ORTH = COST_W'(1 << FRAC_BITS);
	localparam logic [COST_W-1:0] STEP_DIAG =
		COST_W'(int'(1.4142135623730951 * real'(1 << FRAC_BITS)));

	// Squared distance, scaled distance root and its digit-by-digit unit.
	localparam int D2_W     = 2 * XW + 1;
	localparam int SQ_VW    = D2_W + 2 * FRAC_BITS;
	localparam int SQ_STEPS = (SQ_VW + 1) / 2;
	localparam int SQ_RW    = SQ_STEPS;
	localparam int SQ_CW    = $clog2(SQ_STEPS);
	localparam logic [SQ_VW-1:0] SQ_BIT0 = SQ_VW'(1) << (2 * (SQ_STEPS - 1));

	localparam logic [CFG_W-1:0] USE_MAX_W = CFG_W'(GRID_W);
	localparam logic [CFG_W-1:0] USE_MAX_H = CFG_W'(GRID_H);

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	localparam logic [FLAG_W-1:0] FL_NONE   = 2'd0;
	localparam logic [FLAG_W-1:0] FL_OPEN   = 2'd1;
	localparam logic [FLAG_W-1:0] FL_CLOSED = 2'd2;

	localparam logic [DIR_W-1:0] DIR_NONE = 4'd8;
	localparam logic [NB_W-1:0]  NB_LAST  = 3'd7;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_SEARCH = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [FLAG_W-1:0] flags;
		logic [DIR_W-1:0]  parent;
		logic [COST_W-1:0] cost;
		logic [EST_W-1:0]  est;
	} cell_word_t;

	typedef enum logic [3:0] {
		ST_RST_CLR,
		ST_IDLE,
		ST_DISPATCH,
		ST_RD_RES,
		ST_S_CLR,
		ST_S_START,
		ST_NB_RD,
		ST_NB_EVAL,
		ST_NB_WAIT,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_RESP
	} state_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_CLR_ALL,
		CMD_CLR_CELL,
		CMD_LATCH,
		CMD_OBS_WR,
		CMD_RD_CELL,
		CMD_RD_RES,
		CMD_START,
		CMD_NB_RD,
		CMD_NB_NEXT,
		CMD_NB_EVAL,
		CMD_NB_WR,
		CMD_SCAN_INIT,
		CMD_SCAN,
		CMD_CLOSE_BEST,
		CMD_OUT_LOAD
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic idx_last;
		logic start_in_area;
		logic start_is_goal;
		logic nb_in_area;
		logic nb_last;
		logic nb_skip;
		logic nb_need_wr;
		logic nb_is_goal;
		logic sqrt_done;
		logic best_vld;
		logic out_free;
	} stat_t;

	// Column offset of a neighbor, two's complement, row-major order.
	function automatic logic [1:0] nb_dx(input logic [NB_W-1:0] k);
		logic [1:0] d;
		case (k)
			3'd0, 3'd3, 3'd5: d = 2'b11;
			3'd1, 3'd6:       d = 2'b00;
			default:          d = 2'b01;
		endcase
		return d;
	endfunction

	function automatic logic [1:0] nb_dy(input logic [NB_W-1:0] k);
		logic [1:0] d;
		case (k)
			3'd0, 3'd1, 3'd2: d = 2'b11;
			3'd3, 3'd4:       d = 2'b00;
			default:          d = 2'b01;
		endcase
		return d;
	endfunction

	function automatic logic nb_diag(input logic [NB_W-1:0] k);
		logic r;
		case (k)
			3'd0, 3'd2, 3'd5, 3'd7: r = 1'b1;
			default:                r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/grdp_isqrt.sv
// ----------------------------------------------------------------------------
// grdp_isqrt: rounded square root of a scaled squared distance
// Restoring digit-by-digit root, one result bit per cycle, rounded to
// nearest from the final remainder.
// ----------------------------------------------------------------------------
module grdp_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [grdp_pkg::D2_W-1:0]    d2,
	output logic                         done,
	output logic [grdp_pkg::SQ_RW-1:0]   root
);

	logic [grdp_pkg::SQ_VW-1:0] v_q, res_q, bit_q, trial;
	logic [grdp_pkg::SQ_CW-1:0] cnt_q;
	logic                       busy_q, done_q, take, rnd;

	assign trial = res_q + bit_q;
	assign take  = v_q >= trial;
	assign rnd   = v_q > res_q;
	assign root  = res_q[grdp_pkg::SQ_RW-1:0] + grdp_pkg::SQ_RW'(rnd);
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= grdp_pkg::SQ_CW'(grdp_pkg::SQ_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= {d2, {(2 * grdp_pkg::FRAC_BITS){1'b0}}};
			res_q <= '0;
			bit_q <= grdp_pkg::SQ_BIT0;
		end else if (busy_q) begin
			if (take) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

FILE: design/grdp_dp.sv
// ----------------------------------------------------------------------------
// grdp_dp: datapath of the grid A* planner
// Obstacle map, cell store, neighbor arithmetic, open-cell scan, heuristic
// unit, configuration registers and the result register.
// ----------------------------------------------------------------------------
module grdp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  grdp_pkg::cmd_t                  cmd,
	output grdp_pkg::stat_t                 st,
	input  logic [grdp_pkg::OP_W-1:0]       in_op,
	input  logic [grdp_pkg::XW-1:0]         in_pos_x,
	input  logic [grdp_pkg::YW-1:0]         in_pos_y,
	input  logic                            in_blocked,
	input  logic [grdp_pkg::XW-1:0]         in_goal_x,
	input  logic [grdp_pkg::YW-1:0]         in_goal_y,
	input  logic                            cfg_we,
	input  logic [grdp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [grdp_pkg::CFG_W-1:0]      cfg_wdata,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            goal_found,
	output logic [grdp_pkg::FLAG_W-1:0]     cell_status,
	output logic [grdp_pkg::DIR_W-1:0]      parent_dir,
	output logic [grdp_pkg::COST_W-1:0]     path_cost
);

	grdp_pkg::cell_word_t cell_mem [grdp_pkg::NCELL];
	logic                 obs_mem  [grdp_pkg::NCELL];

	grdp_pkg::cell_word_t cell_rd_q, cell_wd, best_word_q;
	logic                 obs_rd_q, obs_wd, cell_we, obs_we;
	logic [grdp_pkg::AW-1:0] addr, nb_addr, idx_q, idx_s1, best_idx_q;

	logic [grdp_pkg::CFG_W-1:0]  use_w_q, use_h_q, clamp_v;
	grdp_pkg::op_t               op_q;
	logic [grdp_pkg::XW-1:0]     px_q, gx_q, cur_x_q;
	logic [grdp_pkg::YW-1:0]     py_q, gy_q, cur_y_q;
	logic                        blk_q;
	logic [grdp_pkg::COST_W-1:0] cur_cost_q, tg_q, tg, step;
	logic [grdp_pkg::NB_W-1:0]   nb_q;
	logic                        best_vld_q, scan_vld_s1, hit;

	logic [grdp_pkg::XW+1:0] nx, dxh;
	logic [grdp_pkg::YW+1:0] ny, dyh;
	logic [grdp_pkg::XW-1:0] adx;
	logic [grdp_pkg::YW-1:0] ady;
	logic [2*grdp_pkg::XW-1:0] sqx;
	logic [2*grdp_pkg::YW-1:0] sqy;
	logic [grdp_pkg::D2_W-1:0] d2;
	logic [grdp_pkg::COST_W:0] tg_sum;
	logic [grdp_pkg::EST_W:0]  est_sum;
	logic [grdp_pkg::EST_W-1:0] est;
	logic [grdp_pkg::SQ_RW-1:0] root;
	logic                       sqrt_done;

	logic                        res_found_q, out_valid_q;
	logic [grdp_pkg::FLAG_W-1:0] res_status_q;
	logic [grdp_pkg::DIR_W-1:0]  res_parent_q;
	logic [grdp_pkg::COST_W-1:0] res_cost_q;

	grdp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd == grdp_pkg::CMD_NB_EVAL),
		.d2     (d2),
		.done   (sqrt_done),
		.root   (root)
	);

	// Neighbor position; a step below zero wraps and sets the top bit.
	always_comb begin
		nx = {2'b00, cur_x_q} + {{grdp_pkg::XW{grdp_pkg::nb_dx(nb_q)[1]}},
			grdp_pkg::nb_dx(nb_q)};
		ny = {2'b00, cur_y_q} + {{grdp_pkg::YW{grdp_pkg::nb_dy(nb_q)[1]}},
			grdp_pkg::nb_dy(nb_q)};
		nb_addr = {ny[grdp_pkg::YW-1:0], nx[grdp_pkg::XW-1:0]};
		dxh = nx - {2'b00, gx_q};
		dyh = ny - {2'b00, gy_q};
		adx = dxh[grdp_pkg::XW+1] ? grdp_pkg::XW'(~dxh + 1'b1) : dxh[grdp_pkg::XW-1:0];
		ady = dyh[grdp_pkg::YW+1] ? grdp_pkg::YW'(~dyh + 1'b1) : dyh[grdp_pkg::YW-1:0];
		sqx = adx * adx;
		sqy = ady * ady;
		d2  = {1'b0, sqx} + {1'b0, sqy};
		step   = grdp_pkg::nb_diag(nb_q) ? grdp_pkg::STEP_DIAG : grdp_pkg::STEP_ORTH;
		tg_sum = {1'b0, cur_cost_q} + {1'b0, step};
		tg     = tg_sum[grdp_pkg::COST_W] ? grdp_pkg::COST_MAX
			: tg_sum[grdp_pkg::COST_W-1:0];
		est_sum = {2'b00, tg_q} + (grdp_pkg::EST_W + 1)'(root);
		est     = est_sum[grdp_pkg::EST_W] ? grdp_pkg::EST_MAX
			: est_sum[grdp_pkg::EST_W-1:0];
	end

	always_comb begin
		cell_we = 1'b0;
		obs_we  = 1'b0;
		cell_wd = '0;
		obs_wd  = 1'b0;
		addr    = idx_q;
		case (cmd)
			grdp_pkg::CMD_CLR_ALL: begin
				cell_we = 1'b1;
				obs_we  = 1'b1;
			end
			grdp_pkg::CMD_CLR_CELL: cell_we = 1'b1;
			grdp_pkg::CMD_OBS_WR: begin
				addr   = {py_q, px_q};
				obs_we = 1'b1;
				obs_wd = blk_q;
			end
			grdp_pkg::CMD_RD_CELL: addr = {py_q, px_q};
			grdp_pkg::CMD_START: begin
				addr           = {py_q, px_q};
				cell_we        = 1'b1;
				cell_wd.flags  = grdp_pkg::FL_CLOSED;
				cell_wd.parent = grdp_pkg::DIR_NONE;
			end
			grdp_pkg::CMD_NB_RD: addr = nb_addr;
			grdp_pkg::CMD_NB_WR: begin
				addr           = nb_addr;
				cell_we        = 1'b1;
				cell_wd.flags  = grdp_pkg::FL_OPEN;
				// Seen from the neighbor, the parent lies opposite the scan direction.
				cell_wd.parent = {1'b0, grdp_pkg::NB_LAST - nb_q};
				cell_wd.cost   = tg_q;
				cell_wd.est    = est;
			end
			grdp_pkg::CMD_CLOSE_BEST: begin
				addr          = best_idx_q;
				cell_we       = 1'b1;
				cell_wd       = best_word_q;
				cell_wd.flags = grdp_pkg::FL_CLOSED;
			end
			default: addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[addr] <= cell_wd;
		end
		cell_rd_q <= cell_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (obs_we) begin
			obs_mem[addr] <= obs_wd;
		end
		obs_rd_q <= obs_mem[addr];
	end

	// Strict compare while scanning upward keeps the lowest index on ties.
	assign hit = scan_vld_s1 && (cell_rd_q.flags == grdp_pkg::FL_OPEN)
		&& (!best_vld_q || (cell_rd_q.est < best_word_q.est));

	always_comb begin
		if (cfg_wdata == '0) begin
			clamp_v = grdp_pkg::CFG_W'(1);
		end else begin
			clamp_v = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_w_q     <= grdp_pkg::USE_MAX_W;
			use_h_q     <= grdp_pkg::USE_MAX_H;
			idx_q       <= '0;
			nb_q        <= '0;
			best_vld_q  <= 1'b0;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == grdp_pkg::CFG_WIDTH) begin
				use_w_q <= (clamp_v > grdp_pkg::USE_MAX_W) ? grdp_pkg::USE_MAX_W : clamp_v;
			end
			if (cfg_we && cfg_idx == grdp_pkg::CFG_HEIGHT) begin
				use_h_q <= (clamp_v > grdp_pkg::USE_MAX_H) ? grdp_pkg::USE_MAX_H : clamp_v;
			end
			case (cmd)
				grdp_pkg::CMD_CLR_ALL, grdp_pkg::CMD_CLR_CELL, grdp_pkg::CMD_SCAN:
					idx_q <= idx_q + 1'b1;
				grdp_pkg::CMD_LATCH, grdp_pkg::CMD_SCAN_INIT: idx_q <= '0;
				default: idx_q <= idx_q;
			endcase
			case (cmd)
				grdp_pkg::CMD_START, grdp_pkg::CMD_CLOSE_BEST: nb_q <= '0;
				grdp_pkg::CMD_NB_NEXT, grdp_pkg::CMD_NB_WR:    nb_q <= nb_q + 1'b1;
				default:                                       nb_q <= nb_q;
			endcase
			if (cmd == grdp_pkg::CMD_SCAN_INIT) begin
				best_vld_q <= 1'b0;
			end else if (hit) begin
				best_vld_q <= 1'b1;
			end
			scan_vld_s1 <= (cmd == grdp_pkg::CMD_SCAN);
			if (cmd == grdp_pkg::CMD_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (hit) begin
			best_idx_q  <= idx_s1;
			best_word_q <= cell_rd_q;
		end
		case (cmd)
			grdp_pkg::CMD_LATCH: begin
				op_q         <= grdp_pkg::op_t'(in_op);
				px_q         <= in_pos_x;
				py_q         <= in_pos_y;
				blk_q        <= in_blocked;
				gx_q         <= in_goal_x;
				gy_q         <= in_goal_y;
				res_found_q  <= 1'b0;
				res_status_q <= grdp_pkg::FL_NONE;
				res_parent_q <= '0;
				res_cost_q   <= '0;
			end
			grdp_pkg::CMD_RD_RES: begin
				res_status_q <= cell_rd_q.flags;
				if (cell_rd_q.flags != grdp_pkg::FL_NONE) begin
					res_parent_q <= cell_rd_q.parent;
					res_cost_q   <= cell_rd_q.cost;
				end else begin
					res_parent_q <= grdp_pkg::DIR_NONE;
					res_cost_q   <= '0;
				end
			end
			grdp_pkg::CMD_START: begin
				cur_x_q     <= px_q;
				cur_y_q     <= py_q;
				cur_cost_q  <= '0;
				res_found_q <= (px_q == gx_q) && (py_q == gy_q);
			end
			grdp_pkg::CMD_NB_EVAL: tg_q <= tg;
			grdp_pkg::CMD_NB_WR: begin
				if (st.nb_is_goal) begin
					res_found_q <= 1'b1;
					res_cost_q  <= tg_q;
				end
			end
			grdp_pkg::CMD_CLOSE_BEST: begin
				cur_x_q    <= best_idx_q[grdp_pkg::XW-1:0];
				cur_y_q    <= best_idx_q[grdp_pkg::AW-1:grdp_pkg::XW];
				cur_cost_q <= best_word_q.cost;
			end
			grdp_pkg::CMD_OUT_LOAD: begin
				goal_found  <= res_found_q;
				cell_status <= res_status_q;
				parent_dir  <= res_parent_q;
				path_cost   <= res_cost_q;
			end
			default: tg_q <= tg_q;
		endcase
	end

	always_comb begin
		st.op            = op_q;
		st.idx_last      = (idx_q == grdp_pkg::AW'(grdp_pkg::NCELL - 1));
		st.start_in_area = ({1'b0, px_q} < use_w_q) && ({1'b0, py_q} < use_h_q);
		st.start_is_goal = (px_q == gx_q) && (py_q == gy_q);
		st.nb_in_area    = !nx[grdp_pkg::XW+1] && !ny[grdp_pkg::YW+1]
			&& (nx[grdp_pkg::XW:0] < use_w_q) && (ny[grdp_pkg::YW:0] < use_h_q);
		st.nb_last       = (nb_q == grdp_pkg::NB_LAST);
		st.nb_skip       = obs_rd_q || (cell_rd_q.flags == grdp_pkg::FL_CLOSED);
		st.nb_need_wr    = (cell_rd_q.flags != grdp_pkg::FL_OPEN) || (tg < cell_rd_q.cost);
		st.nb_is_goal    = (nx[grdp_pkg::XW-1:0] == gx_q) && (ny[grdp_pkg::YW-1:0] == gy_q);
		st.sqrt_done     = sqrt_done;
		st.best_vld      = best_vld_q;
		st.out_free      = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/grdp_ctrl.sv
// ----------------------------------------------------------------------------
// grdp_ctrl: sequencer of the grid A* planner
// Walks the clearing passes, the neighbor relaxation, the open-cell scan
// and the result hand-off, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module grdp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  grdp_pkg::stat_t  st,
	output grdp_pkg::cmd_t   cmd
);

	grdp_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grdp_pkg::ST_RST_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = grdp_pkg::CMD_NOP;
		case (state_q)
			grdp_pkg::ST_RST_CLR: begin
				cmd = grdp_pkg::CMD_CLR_ALL;
				if (st.idx_last) state_nxt = grdp_pkg::ST_IDLE;
			end
			grdp_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd       = grdp_pkg::CMD_LATCH;
					state_nxt = grdp_pkg::ST_DISPATCH;
				end
			end
			grdp_pkg::ST_DISPATCH: begin
				case (st.op)
					grdp_pkg::OP_WRITE: begin
						cmd       = grdp_pkg::CMD_OBS_WR;
						state_nxt = grdp_pkg::ST_RESP;
					end
					grdp_pkg::OP_SEARCH: state_nxt = grdp_pkg::ST_S_CLR;
					grdp_pkg::OP_READ: begin
						cmd       = grdp_pkg::CMD_RD_CELL;
						state_nxt = grdp_pkg::ST_RD_RES;
					end
					default: state_nxt = grdp_pkg::ST_RESP;
				endcase
			end
			grdp_pkg::ST_RD_RES: begin
				cmd       = grdp_pkg::CMD_RD_RES;
				state_nxt = grdp_pkg::ST_RESP;
			end
			grdp_pkg::ST_S_CLR: begin
				cmd = grdp_pkg::CMD_CLR_CELL;
				if (st.idx_last) state_nxt = grdp_pkg::ST_S_START;
			end
			grdp_pkg::ST_S_START: begin
				if (!st.start_in_area) begin
					state_nxt = grdp_pkg::ST_RESP;
				end else begin
					cmd       = grdp_pkg::CMD_START;
					state_nxt = st.start_is_goal ? grdp_pkg::ST_RESP : grdp_pkg::ST_NB_RD;
				end
			end
			grdp_pkg::ST_NB_RD: begin
				if (st.nb_in_area) begin
					cmd       = grdp_pkg::CMD_NB_RD;
					state_nxt = grdp_pkg::ST_NB_EVAL;
				end else if (st.nb_last) begin
					state_nxt = grdp_pkg::ST_SCAN_INIT;
				end else begin
					cmd = grdp_pkg::CMD_NB_NEXT;
				end
			end
			grdp_pkg::ST_NB_EVAL: begin
				if (!st.nb_skip && st.nb_need_wr) begin
					cmd       = grdp_pkg::CMD_NB_EVAL;
					state_nxt = grdp_pkg::ST_NB_WAIT;
				end else if (st.nb_last) begin
					state_nxt = grdp_pkg::ST_SCAN_INIT;
				end else begin
					cmd       = grdp_pkg::CMD_NB_NEXT;
					state_nxt = grdp_pkg::ST_NB_RD;
				end
			end
			grdp_pkg::ST_NB_WAIT: begin
				if (st.sqrt_done) begin
					cmd = grdp_pkg::CMD_NB_WR;
					// The goal can only turn open on its first discovery.
					if (st.nb_is_goal) begin
						state_nxt = grdp_pkg::ST_RESP;
					end else if (st.nb_last) begin
						state_nxt = grdp_pkg::ST_SCAN_INIT;
					end else begin
						state_nxt = grdp_pkg::ST_NB_RD;
					end
				end
			end
			grdp_pkg::ST_SCAN_INIT: begin
				cmd       = grdp_pkg::CMD_SCAN_INIT;
				state_nxt = grdp_pkg::ST_SCAN;
			end
			grdp_pkg::ST_SCAN: begin
				cmd = grdp_pkg::CMD_SCAN;
				if (st.idx_last) state_nxt = grdp_pkg::ST_SCAN_END;
			end
			grdp_pkg::ST_SCAN_END: state_nxt = grdp_pkg::ST_PICK;
			grdp_pkg::ST_PICK: begin
				if (st.best_vld) begin
					cmd       = grdp_pkg::CMD_CLOSE_BEST;
					state_nxt = grdp_pkg::ST_NB_RD;
				end else begin
					state_nxt = grdp_pkg::ST_RESP;
				end
			end
			grdp_pkg::ST_RESP: begin
				if (st.out_free) begin
					cmd       = grdp_pkg::CMD_OUT_LOAD;
					state_nxt = grdp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = grdp_pkg::ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != grdp_pkg::ST_IDLE);

	a_sqrt_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.sqrt_done |-> state_q == grdp_pkg::ST_NB_WAIT)
		else $error("heuristic finished outside the relaxation wait");

	a_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == grdp_pkg::CMD_CLOSE_BEST |-> st.best_vld)
		else $error("closing a cell without an open candidate");

	a_eval_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == grdp_pkg::ST_NB_EVAL |-> $past(state_q) == grdp_pkg::ST_NB_RD)
		else $error("neighbor evaluated without a preceding read");

endmodule

FILE: design/grid_astar_planner.sv
// ----------------------------------------------------------------------------
// grid_astar_planner: A* path search on an 8-connected 64x64 grid
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// After reset the block sweeps its obstacle map and cell store with
// in_stall high. A search first clears the cell store; then, for each
// closed cell, every neighbor whose cost is set waits on the heuristic
// square root, which yields one bit per cycle, and picking the next cell
// scans the whole store through its single memory port.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module grid_astar_planner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [grdp_pkg::OP_W-1:0]       op,
	input  logic [grdp_pkg::XW-1:0]         pos_x,
	input  logic [grdp_pkg::YW-1:0]         pos_y,
	input  logic                            blocked,
	input  logic [grdp_pkg::XW-1:0]         goal_x,
	input  logic [grdp_pkg::YW-1:0]         goal_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            goal_found,
	output logic [grdp_pkg::FLAG_W-1:0]     cell_status,
	output logic [grdp_pkg::DIR_W-1:0]      parent_dir,
	output logic [grdp_pkg::COST_W-1:0]     path_cost,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [grdp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grdp_pkg::CFG_W-1:0]      cfg_data
);

	grdp_pkg::cmd_t  cmd;
	grdp_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	grdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	grdp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_op       (op),
		.in_pos_x    (pos_x),
		.in_pos_y    (pos_y),
		.in_blocked  (blocked),
		.in_goal_x   (goal_x),
		.in_goal_y   (goal_y),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_idx     (cfg_index),
		.cfg_wdata   (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.goal_found  (goal_found),
		.cell_status (cell_status),
		.parent_dir  (parent_dir),
		.path_cost   (path_cost)
	);

endmodule

FILE: sim/grid_astar_planner_check.sv
// ----------------------------------------------------------------------------
// grid_astar_planner_check: result predictor and scoreboard for the planner
// Watches the configuration, command and result channels, keeps its own
// obstacle map and cell store, and compares every result beat in order.
// ----------------------------------------------------------------------------
module grid_astar_planner_check
	import grdp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [OP_W-1:0]      op,
	input  logic [XW-1:0]        pos_x,
	input  logic [YW-1:0]        pos_y,
	input  logic                 blocked,
	input  logic [XW-1:0]        goal_x,
	input  logic [YW-1:0]        goal_y,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 goal_found,
	input  logic [FLAG_W-1:0]    cell_status,
	input  logic [DIR_W-1:0]     parent_dir,
	input  logic [COST_W-1:0]    path_cost,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending,
	output int                   searches,
	output int                   found_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              found;
		logic [FLAG_W-1:0] status;
		logic [DIR_W-1:0]  dir;
		logic [COST_W-1:0] cost;
	} plan_result_t;

	logic              obst_map [NCELL];
	logic [FLAG_W-1:0] flag_mem [NCELL];
	logic [COST_W-1:0] cost_mem [NCELL];
	logic [EST_W-1:0]  est_mem  [NCELL];
	logic [DIR_W-1:0]  dir_mem  [NCELL];
	logic [CFG_W-1:0]  width_reg, height_reg;
	plan_result_t      result_q [$];
	int                goal_cx, goal_cy, area_w, area_h;

	initial begin
		for (int i = 0; i < NCELL; i++) begin
			obst_map[i] = 1'b0;
			flag_mem[i] = FL_NONE;
			cost_mem[i] = '0;
			est_mem[i]  = '0;
			dir_mem[i]  = '0;
		end
		width_reg   = 7'd64;
		height_reg  = 7'd64;
		errors      = 0;
		pending     = 0;
		searches    = 0;
		found_count = 0;
	end

	// Rounded integer square root, digit by digit.
	function automatic longint unsigned root_round(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (v > r) r = r + 1;
		return r;
	endfunction

	function automatic longint unsigned dist_fixed(int dx, int dy);
		longint unsigned d2;
		d2 = longint'(dx * dx + dy * dy);
		return root_round(d2 << (2 * FRAC_BITS));
	endfunction

	function automatic logic [EST_W-1:0] estimate(logic [COST_W-1:0] g, int x, int y);
		longint unsigned f;
		f = g + dist_fixed(x - goal_cx, y - goal_cy);
		return (f > EST_MAX) ? EST_MAX : f[EST_W-1:0];
	endfunction

	// Relaxes the eight neighbors of one closed cell; true once the goal shows up.
	function automatic logic relax_around(int cx, int cy);
		int nx, ny, n, k;
		longint unsigned t;
		logic [COST_W-1:0] tg;
		logic [DIR_W-1:0] pdir;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				nx = cx + dx;
				ny = cy + dy;
				if (dx == 0 && dy == 0) continue;
				if (nx < 0 || ny < 0 || nx >= area_w || ny >= area_h) continue;
				n = ny * GRID_W + nx;
				if (obst_map[n] || flag_mem[n] == FL_CLOSED) continue;
				t = cost_mem[cy * GRID_W + cx] +
					((dx != 0 && dy != 0) ? dist_fixed(1, 1) : dist_fixed(1, 0));
				tg = (t > COST_MAX) ? COST_MAX : t[COST_W-1:0];
				k = (1 - dy) * 3 + (1 - dx);
				pdir = DIR_W'((k < 4) ? k : k - 1);
				if (flag_mem[n] != FL_OPEN) begin
					cost_mem[n] = tg;
					est_mem[n]  = estimate(tg, nx, ny);
					dir_mem[n]  = pdir;
					flag_mem[n] = FL_OPEN;
					if (nx == goal_cx && ny == goal_cy) return 1'b1;
				end else if (tg < cost_mem[n]) begin
					cost_mem[n] = tg;
					est_mem[n]  = estimate(tg, nx, ny);
					dir_mem[n]  = pdir;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic plan_result_t plan_route(int sx, int sy);
		plan_result_t r;
		int s, best;
		logic hit;
		r = '0;
		for (int i = 0; i < NCELL; i++) flag_mem[i] = FL_NONE;
		area_w = (width_reg < 1) ? 1 : (width_reg > GRID_W) ? GRID_W : width_reg;
		area_h = (height_reg < 1) ? 1 : (height_reg > GRID_H) ? GRID_H : height_reg;
		if (sx >= area_w || sy >= area_h) return r;
		s = sy * GRID_W + sx;
		cost_mem[s] = '0;
		est_mem[s]  = estimate('0, sx, sy);
		dir_mem[s]  = DIR_NONE;
		flag_mem[s] = FL_CLOSED;
		if (sx == goal_cx && sy == goal_cy) begin
			r.found = 1'b1;
			return r;
		end
		hit = relax_around(sx, sy);
		while (!hit) begin
			best = -1;
			for (int i = 0; i < NCELL; i++)
				if (flag_mem[i] == FL_OPEN && (best < 0 || est_mem[i] < est_mem[best]))
					best = i;
			if (best < 0) return r;
			flag_mem[best] = FL_CLOSED;
			hit = relax_around(best % GRID_W, best / GRID_W);
		end
		r.found = 1'b1;
		r.cost  = cost_mem[goal_cy * GRID_W + goal_cx];
		return r;
	endfunction

	always @(posedge clk) begin
		plan_result_t want, got;
		int idx;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {goal_found, cell_status, parent_dir, path_cost};
				if (result_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result beat with nothing expected: %p", $realtime, got);
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch found %b/%b status %0d/%0d dir %0d/%0d cost %0d/%0d (exp/act)",
								$realtime, want.found, got.found, want.status, got.status,
								want.dir, got.dir, want.cost, got.cost);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
				else if (cfg_index == CFG_HEIGHT) height_reg = cfg_data;
			end
			if (in_valid && !in_stall) begin
				want = '0;
				idx = pos_y * GRID_W + pos_x;
				case (op_t'(op))
					OP_WRITE: obst_map[idx] = blocked;
					OP_SEARCH: begin
						goal_cx = goal_x;
						goal_cy = goal_y;
						want = plan_route(pos_x, pos_y);
						searches++;
						if (want.found) found_count++;
					end
					OP_READ: begin
						want.dir    = DIR_NONE;
						want.status = flag_mem[idx];
						if (flag_mem[idx] != FL_NONE) begin
							want.dir  = dir_mem[idx];
							want.cost = cost_mem[idx];
						end
					end
					default: ;
				endcase
				result_q = {result_q, want};
			end
			pending = result_q.size();
		end
	end

endmodule

FILE: sim/grid_astar_planner_test.sv
// ----------------------------------------------------------------------------
// grid_astar_planner_test: stimulus and verdict for the grid A* planner
// Runs directed corner cases and then random map writes, cell reads and
// searches over several grid sizes, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module grid_astar_planner_test;
	timeunit 1ns;
	timeprecision 1ps;
	import grdp_pkg::*;

	localparam int LIMIT = 20_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      op = '0;
	logic [XW-1:0]        pos_x = '0;
	logic [YW-1:0]        pos_y = '0;
	logic                 blocked = 1'b0;
	logic [XW-1:0]        goal_x = '0;
	logic [YW-1:0]        goal_y = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 goal_found;
	logic [FLAG_W-1:0]    cell_status;
	logic [DIR_W-1:0]     parent_dir;
	logic [COST_W-1:0]    path_cost;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int errors, pending, searches, found_count;
	int cycles = 0;
	int idle_max = 0;
	int beats_sent = 0;
	logic hold_req = 1'b0;

	always #1 clk = ~clk;

	grid_astar_planner uut (.*);

	grid_astar_planner_check checker_i (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: random stall before each beat, plus one long hold-off on request.
	initial begin
		int w;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req && !held) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				held = 1'b1;
			end
			w = $urandom_range(0, idle_max);
			out_stall <= (w != 0);
			if (w != 0) begin
				repeat (w) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_cmd(op_t o, int x, int y, logic b, int gx, int gy);
		int gap;
		gap = $urandom_range(0, idle_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op       <= o;
		pos_x    <= XW'(x);
		pos_y    <= YW'(y);
		blocked  <= b;
		goal_x   <= XW'(gx);
		goal_y   <= YW'(gy);
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int cw [8] = '{1, 2, 3, 0, 4, 127, 64, 3};
		int ch [8] = '{1, 3, 2, 2, 127, 1, 64, 3};
		int uw, uh, sx, sy, gx, gy, pick;
		logic wide;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed corner cases on the full 64x64 grid.
		send_cmd(OP_READ, 0, 0, 1'b0, 0, 0);
		send_cmd(OP_READ, 63, 63, 1'b0, 0, 0);
		send_cmd(OP_WRITE, 63, 63, 1'b1, 0, 0);
		send_cmd(OP_WRITE, 0, 0, 1'b1, 63, 63);
		send_cmd(OP_WRITE, 0, 0, 1'b0, 0, 0);
		send_cmd(OP_NONE, 63, 63, 1'b1, 63, 63);
		send_cmd(OP_SEARCH, 5, 5, 1'b0, 5, 5);
		send_cmd(OP_READ, 5, 5, 1'b0, 0, 0);
		send_cmd(OP_SEARCH, 10, 10, 1'b0, 11, 11);
		send_cmd(OP_READ, 11, 11, 1'b0, 0, 0);
		send_cmd(OP_READ, 10, 10, 1'b0, 0, 0);
		send_cmd(OP_READ, 9, 9, 1'b0, 0, 0);
		send_cmd(OP_READ, 12, 12, 1'b0, 0, 0);
		send_cmd(OP_WRITE, 20, 20, 1'b1, 0, 0);
		send_cmd(OP_SEARCH, 20, 20, 1'b1, 20, 21);
		send_cmd(OP_READ, 20, 21, 1'b0, 0, 0);
		send_cmd(OP_SEARCH, 63, 62, 1'b0, 62, 62);
		send_cmd(OP_READ, 62, 62, 1'b0, 0, 0);
		send_cmd(OP_READ, 63, 63, 1'b0, 0, 0);

		// Hold the result side off while commands keep coming, then pause the
		// sender until everything is back.
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_cmd(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63), 1'b0, 0, 0);
		drain();

		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_WIDTH, cw[p]);
			write_reg(CFG_HEIGHT, ch[p]);
			uw = (cw[p] < 1) ? 1 : (cw[p] > GRID_W) ? GRID_W : cw[p];
			uh = (ch[p] < 1) ? 1 : (ch[p] > GRID_H) ? GRID_H : ch[p];
			// Large areas get only short searches, since a full walk is very slow.
			wide = (uw * uh > 16);
			idle_max = (p % 3 == 2) ? 0 : 13;
			for (int i = 0; i < 230; i++) begin
				pick = $urandom_range(0, 99);
				sx = $urandom_range(0, uw);
				sy = $urandom_range(0, uh);
				if ($urandom_range(0, 3) == 0) begin
					sx = $urandom_range(0, 63);
					sy = $urandom_range(0, 63);
				end
				if (pick < 40) begin
					send_cmd(OP_WRITE, sx, sy, ($urandom_range(0, 9) < 3), $urandom_range(0, 63),
						$urandom_range(0, 63));
				end else if (pick < 93) begin
					send_cmd(OP_READ, sx, sy, 1'($urandom_range(0, 1)), $urandom_range(0, 63),
						$urandom_range(0, 63));
				end else if (pick < 96) begin
					send_cmd(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
						1'($urandom_range(0, 1)), $urandom_range(0, 63),
						$urandom_range(0, 63));
				end else if (wide) begin
					sx = $urandom_range(0, uw - 1);
					sy = $urandom_range(0, uh - 1);
					gx = sx + $urandom_range(0, 2) - 1;
					gy = sy + $urandom_range(0, 2) - 1;
					gx = (gx < 0) ? 0 : (gx >= uw) ? uw - 1 : gx;
					gy = (gy < 0) ? 0 : (gy >= uh) ? uh - 1 : gy;
					send_cmd(OP_WRITE, gx, gy, 1'b0, 0, 0);
					send_cmd(OP_SEARCH, sx, sy, 1'b0, gx, gy);
					send_cmd(OP_READ, gx, gy, 1'b0, 0, 0);
				end else begin
					gx = $urandom_range(0, uw);
					gy = $urandom_range(0, uh);
					if ($urandom_range(0, 4) == 0) gx = $urandom_range(0, 63);
					send_cmd(OP_SEARCH, sx, sy, 1'($urandom_range(0, 1)), gx, gy);
					send_cmd(OP_READ, gx, gy, 1'b0, 0, 0);
				end
			end
			drain();
		end

		repeat (50) @(negedge clk);
		$display("Sent %0d commands over 8 grid sizes plus directed cases;", beats_sent);
		$display("%0d searches ran, %0d of them reached the goal.", searches, found_count);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: grid_astar_planner.f
design/grdp_pkg.sv
design/grdp_isqrt.sv
design/grdp_dp.sv
design/grdp_ctrl.sv
design/grid_astar_planner.sv
sim/grid_astar_planner_check.sv
sim/grid_astar_planner_test.sv
